// ----- design/scfs_pkg.sv -----
`default_nettype none
package scfs_pkg;

	localparam int REGION_BYTES_DEF    = 2097152;
	localparam int NUM_CLASSES_DEF     = 8;
	localparam int MIN_CHUNK_BYTES_DEF = 32;

	localparam int ADDR_W   = 48;
	localparam int SIZE_W   = 32;
	localparam int CLSO_W   = 3;
	localparam int STATUS_W = 3;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_ZERO      = 3'd1;
	localparam status_t ST_OOM       = 3'd2;
	localparam status_t ST_BADADDR   = 3'd3;
	localparam status_t ST_UNDERFLOW = 3'd4;
	localparam status_t ST_OVERSIZE  = 3'd5;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic zero;
		logic over;
	} size_flags_t;

	// first stack entry of class c: classes are packed back to back,
	// class k holding cap0 >> k entries
	function automatic int cls_start(input int cap0, input int c);
		int s;
		s = 0;
		for (int k = 0; k < c; k++) begin
			s = s + (cap0 >> k);
		end
		return s;
	endfunction

endpackage
`default_nettype wire

// ----- design/size_class_free_stack_allocator.sv -----
`default_nettype none
// Chunk allocator over one region split into NUM_CLASSES equal segments, class c
// serving chunks of MIN_CHUNK_BYTES << c from segment c through a stack of free
// offsets kept in one RAM with one write and one read port. Raise start while
// busy is low; the result appears on alloc_addr/size_class/status for exactly
// one cycle with done high and cannot be stalled, so the receiver must take it
// then. A zero or oversize allocate finishes straight from idle; an allocate
// runs the class probe, which checks one count per cycle and steps over each
// exhausted class (out of memory after the last), then the registered stack
// read; a free runs subtract, segment decode and stack write, and ends after
// the decode when the address is outside the region. No init walk after
// reset: a per-class fill mark tells which stack entries were ever written, and
// untouched entries read as their ascending initial offset computed on the fly.
// region_base is written only while idle.
module size_class_free_stack_allocator #(
	parameter int REGION_BYTES    = scfs_pkg::REGION_BYTES_DEF,
	parameter int NUM_CLASSES     = scfs_pkg::NUM_CLASSES_DEF,
	parameter int MIN_CHUNK_BYTES = scfs_pkg::MIN_CHUNK_BYTES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            req_type,
	input  wire logic [scfs_pkg::SIZE_W-1:0]     req_size,
	input  wire logic [scfs_pkg::ADDR_W-1:0]     free_addr,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [scfs_pkg::ADDR_W-1:0]     cfg_data,
	output logic                                 done,
	output logic [scfs_pkg::ADDR_W-1:0]          alloc_addr,
	output logic [scfs_pkg::CLSO_W-1:0]          size_class,
	output scfs_pkg::status_t                    status
);
	import scfs_pkg::*;

	localparam int SEG_BYTES = REGION_BYTES / NUM_CLASSES;
	localparam int MIN_LG    = $clog2(MIN_CHUNK_BYTES);
	localparam int CAP0      = SEG_BYTES >> MIN_LG;
	localparam int CNT_W     = $clog2(CAP0 + 1);
	localparam int DEPTH     = cls_start(CAP0, NUM_CLASSES);
	localparam int RA_W      = $clog2(DEPTH);
	localparam int OFF_W     = $clog2(REGION_BYTES);
	localparam int CLS_W     = $clog2(NUM_CLASSES);
	localparam int LIMIT     = NUM_CLASSES * SEG_BYTES;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PROBE = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_FSUB  = 3'd3;
	localparam logic [2:0] S_FCHK  = 3'd4;
	localparam logic [2:0] S_FUPD  = 3'd5;

	// per-class constants
	logic [RA_W-1:0]  start_tbl [NUM_CLASSES];
	logic [CNT_W-1:0] cap_tbl   [NUM_CLASSES];
	logic [OFF_W-1:0] base_tbl  [NUM_CLASSES];

	for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_tbl
		assign start_tbl[g] = RA_W'(cls_start(CAP0, g));
		assign cap_tbl[g]   = CNT_W'(CAP0 >> g);
		assign base_tbl[g]  = OFF_W'(g * SEG_BYTES);
	end

	// control state
	logic [2:0]        state_q;
	logic [CNT_W-1:0]  used_q [NUM_CLASSES];
	logic [CNT_W-1:0]  hwm_q  [NUM_CLASSES];
	logic              done_q;
	logic [ADDR_W-1:0] region_base_q;

	// payload
	logic              type_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CLS_W-1:0]  cls_q;
	logic [CLS_W-1:0]  fit_q;
	logic              valid_q;
	logic [OFF_W-1:0]  init_q;
	logic [ADDR_W:0]   diff_q;
	logic [OFF_W-1:0]  off_q;
	logic [ADDR_W-1:0] alloc_addr_q;
	logic [CLSO_W-1:0] size_class_q;
	status_t           status_q;

	size_flags_t       sz_flags;
	logic [CLS_W-1:0]  sz_fit;
	logic              seg_bad;
	logic [CLS_W-1:0]  seg_cls;
	logic [OFF_W-1:0]  seg_off;

	logic [CNT_W-1:0]  cur_used;
	logic [CNT_W-1:0]  cur_hwm;
	logic              has_room;
	logic              last_cls;
	logic [4:0]        shamt;
	logic [OFF_W-1:0]  init_off;
	logic              rd_en;
	logic [RA_W-1:0]   rd_addr;
	logic              wr_en;
	logic [RA_W-1:0]   wr_addr;
	logic [OFF_W-1:0]  rd_data;
	logic [OFF_W-1:0]  grant_off;

	scfs_size_dec #(
		.NUM_CLASSES     (NUM_CLASSES),
		.MIN_CHUNK_BYTES (MIN_CHUNK_BYTES),
		.CLS_W           (CLS_W)
	) u_size_dec (
		.size  (req_size),
		.flags (sz_flags),
		.fit   (sz_fit)
	);

	scfs_seg_dec #(
		.NUM_CLASSES (NUM_CLASSES),
		.SEG_BYTES   (SEG_BYTES),
		.OFF_W       (OFF_W),
		.CLS_W       (CLS_W)
	) u_seg_dec (
		.diff (diff_q),
		.bad  (seg_bad),
		.cls  (seg_cls),
		.off  (seg_off)
	);

	scfs_stack_ram #(
		.DEPTH (DEPTH),
		.AW    (RA_W),
		.DW    (OFF_W)
	) u_stack_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (off_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// shared per-class unit: one count, one compare, one read and one write stack address per cycle
	always_comb begin
		cur_used = used_q[cls_q];
		cur_hwm  = hwm_q[cls_q];
		has_room = cur_used < cap_tbl[cls_q];
		last_cls = (cls_q == CLS_W'(NUM_CLASSES - 1));
		shamt    = 5'(MIN_LG) + 5'(cls_q);
		// never-written entry j of class c holds c*SEG + j*chunk
		init_off = base_tbl[cls_q] + (OFF_W'(cur_used) << shamt);
		rd_en    = (state_q == S_PROBE) && has_room;
		rd_addr  = start_tbl[cls_q] + RA_W'(cur_used);
		wr_en    = (state_q == S_FUPD) && (cur_used != '0);
		wr_addr  = start_tbl[cls_q] + RA_W'(cur_used - CNT_W'(1));
		grant_off = valid_q ? rd_data : init_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			done_q        <= 1'b0;
			region_base_q <= '0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				used_q[c] <= '0;
				hwm_q[c]  <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				region_base_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (req_type == REQ_FREE) begin
							state_q <= S_FSUB;
						end else if (sz_flags.zero || sz_flags.over) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					if (has_room) begin
						used_q[cls_q] <= cur_used + CNT_W'(1);
						// fill mark follows the deepest entry ever popped
						if (cur_used == cur_hwm) begin
							hwm_q[cls_q] <= cur_used + CNT_W'(1);
						end
						state_q <= S_READ;
					end else if (last_cls) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_FSUB: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					if (seg_bad) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_FUPD;
					end
				end
				S_FUPD: begin
					if (cur_used != '0) begin
						used_q[cls_q] <= cur_used - CNT_W'(1);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					type_q       <= req_type;
					addr_q       <= free_addr;
					cls_q        <= sz_fit;
					fit_q        <= sz_fit;
					alloc_addr_q <= '0;
					size_class_q <= '0;
					status_q     <= sz_flags.zero ? ST_ZERO : ST_OVERSIZE;
				end
			end
			S_PROBE: begin
				if (has_room) begin
					valid_q <= cur_used < cur_hwm;
					init_q  <= init_off;
				end else if (!last_cls) begin
					cls_q <= cls_q + CLS_W'(1);
				end else begin
					status_q     <= ST_OOM;
					size_class_q <= CLSO_W'(fit_q);
				end
			end
			S_READ: begin
				alloc_addr_q <= region_base_q + ADDR_W'(grant_off);
				size_class_q <= CLSO_W'(cls_q);
				status_q     <= ST_OK;
			end
			S_FSUB: begin
				diff_q <= {1'b0, addr_q} - {1'b0, region_base_q};
			end
			S_FCHK: begin
				cls_q    <= seg_cls;
				off_q    <= seg_off;
				status_q <= ST_BADADDR;
			end
			S_FUPD: begin
				size_class_q <= CLSO_W'(cls_q);
				status_q     <= (cur_used == '0) ? ST_UNDERFLOW : ST_OK;
			end
			default: begin
				status_q <= ST_OK;
			end
		endcase
	end

	assign busy       = (state_q != S_IDLE);
	assign cfg_ready  = (state_q == S_IDLE);
	assign done       = done_q;
	assign alloc_addr = alloc_addr_q;
	assign size_class = size_class_q;
	assign status     = status_q;

`ifndef SYNTHESIS
	ap_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy) || $past(start))
		else $error("result strobe without a transaction in flight");

	ap_hwm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PROBE |-> cur_used <= cur_hwm)
		else $error("class count beyond its fill mark");

	ap_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PROBE |-> cur_used <= cap_tbl[cls_q])
		else $error("class count beyond its capacity");

	ap_free_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (type_q == REQ_FREE) |-> alloc_addr_q == '0)
		else $error("free returned a nonzero address");

	ap_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (type_q == REQ_ALLOC) && (status_q == ST_OK)
		|-> ADDR_W'(alloc_addr_q - region_base_q) < ADDR_W'(LIMIT))
		else $error("granted chunk outside the region");
`endif

endmodule
`default_nettype wire

// ----- design/scfs_size_dec.sv -----
`default_nettype none
module scfs_size_dec #(
	parameter int NUM_CLASSES     = scfs_pkg::NUM_CLASSES_DEF,
	parameter int MIN_CHUNK_BYTES = scfs_pkg::MIN_CHUNK_BYTES_DEF,
	parameter int CLS_W           = $clog2(NUM_CLASSES)
) (
	input  wire logic [scfs_pkg::SIZE_W-1:0] size,
	output scfs_pkg::size_flags_t             flags,
	output logic [CLS_W-1:0]                  fit
);
	import scfs_pkg::*;

	localparam int MAX_CHUNK = MIN_CHUNK_BYTES << (NUM_CLASSES - 1);

	always_comb begin
		flags.zero = (size == '0);
		flags.over = (size > SIZE_W'(MAX_CHUNK));
		fit = '0;
		// smallest class whose chunk holds the size
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (size <= SIZE_W'(MIN_CHUNK_BYTES << c)) begin
				fit = CLS_W'(c);
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/scfs_seg_dec.sv -----
`default_nettype none
module scfs_seg_dec #(
	parameter int NUM_CLASSES = scfs_pkg::NUM_CLASSES_DEF,
	parameter int SEG_BYTES   = scfs_pkg::REGION_BYTES_DEF / scfs_pkg::NUM_CLASSES_DEF,
	parameter int OFF_W       = $clog2(scfs_pkg::REGION_BYTES_DEF),
	parameter int CLS_W       = $clog2(NUM_CLASSES)
) (
	input  wire logic [scfs_pkg::ADDR_W:0] diff,
	output logic                           bad,
	output logic [CLS_W-1:0]               cls,
	output logic [OFF_W-1:0]               off
);
	import scfs_pkg::*;

	localparam int LIMIT = NUM_CLASSES * SEG_BYTES;

	// diff carries the borrow of addr - base in its top bit
	always_comb begin
		bad = diff[ADDR_W] || (diff[ADDR_W-1:0] >= ADDR_W'(LIMIT));
		cls = '0;
		for (int k = 1; k < NUM_CLASSES; k++) begin
			if (diff[ADDR_W-1:0] >= ADDR_W'(k * SEG_BYTES)) begin
				cls = CLS_W'(k);
			end
		end
		off = diff[OFF_W-1:0];
	end

endmodule
`default_nettype wire

// ----- design/scfs_stack_ram.sv -----
`default_nettype none
module scfs_stack_ram #(
	parameter int DEPTH = 16320,
	parameter int AW    = $clog2(DEPTH),
	parameter int DW    = 21
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data
);
	import scfs_pkg::*;

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire
